[design/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes, types and helpers of the bounded deque unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int DATA_W     = 32;
    localparam int ELEM_CNT_W = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_QUERY      = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the accepted command
        logic exec;      // apply push, pop check, clear
        logic popsub;    // finish a pop with the read entry
        logic scan;      // walk the held entries for the maximum
        logic out_load;  // capture the result into the output register
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic need_sub;
        logic scan_done;
    } t_dp_sts;

    // Circular slot: (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
    function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

[design/bdq_cmd_if.sv]
// ----------------------------------------------------------------------------
// bdq_cmd_if
// Command channel: valid/ready handshake with command code and value.
// ----------------------------------------------------------------------------
interface bdq_cmd_if
    import bdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

[design/bdq_res_if.sv]
// ----------------------------------------------------------------------------
// bdq_res_if
// Result channel: valid/ready handshake with status and queue statistics.
// ----------------------------------------------------------------------------
interface bdq_res_if
    import bdq_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic signed [ELEM_CNT_W-1:0] element_count;
    logic signed [DATA_W-1:0]     element_sum;
    logic signed [DATA_W-1:0]     largest_value;

    modport source (output valid, output status, output element_count,
                    output element_sum, output largest_value, input ready);
    modport sink   (input valid, input status, input element_count,
                    input element_sum, input largest_value, output ready);
endinterface

[design/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: steps one command through execute, pop fixup, scan and output.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POPSUB,
        S_SCAN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = i_sts.need_sub ? S_POPSUB : S_SCAN;
            end
            S_POPSUB: begin
                o_ctl.popsub = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[design/bdq_dpath.sv]
// ----------------------------------------------------------------------------
// bdq_dpath
// Element store, front/count/sum registers, maximum scan and result register.
// ----------------------------------------------------------------------------
module bdq_dpath
    import bdq_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_ctl                      i_ctl,
    output t_dp_sts                      o_sts,
    input  logic [CMD_W-1:0]             i_command,
    input  logic signed [DATA_W-1:0]     i_value,
    output logic [STATUS_W-1:0]          o_status,
    output logic signed [ELEM_CNT_W-1:0] o_element_count,
    output logic signed [DATA_W-1:0]     o_element_sum,
    output logic signed [DATA_W-1:0]     o_largest_value
);

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   r_rdata;

    logic [CMD_W-1:0]    r_cmd;
    logic [DATA_W-1:0]   r_val;
    logic [IDX_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_sum, n_sum;
    t_status             r_status, n_status;
    logic [CNT_W-1:0]    r_scan_idx;
    logic                r_rd_pend;
    logic                r_first;
    logic [DATA_W-1:0]   r_best;

    logic [STATUS_W-1:0]   r_out_status;
    logic [ELEM_CNT_W-1:0] r_out_count;
    logic [DATA_W-1:0]     r_out_sum;
    logic [DATA_W-1:0]     r_out_max;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                is_full;
    logic                is_empty;
    logic                scan_issue;
    logic [IDX_W-1:0]    front_dec;

    assign is_full    = (r_count >= CNT_W'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign scan_issue = i_ctl.scan && (r_scan_idx < r_count);
    assign front_dec  = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;

    assign o_sts.need_sub  = ((r_cmd == CMD_POP_FRONT) || (r_cmd == CMD_POP_BACK))
                             && !is_empty;
    assign o_sts.scan_done = !(r_scan_idx < r_count) && !r_rd_pend;

    // Execute the command and finish pops
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_sum    = r_sum;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = front_dec;
        rd_en    = scan_issue;
        rd_addr  = slot_add(r_front, r_scan_idx);
        if (i_ctl.exec) begin
            case (r_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + r_val;
                        if (r_cmd == CMD_PUSH_FRONT) begin
                            n_front = front_dec;
                        end else begin
                            wr_addr = slot_add(r_front, r_count);
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = (r_cmd == CMD_POP_FRONT) ? r_front
                                  : slot_add(r_front, r_count - 1'b1);
                    end
                end
                CMD_CLEAR: begin
                    n_front = '0;
                    n_count = '0;
                    n_sum   = '0;
                end
                default: begin
                end
            endcase
        end else if (i_ctl.popsub) begin
            n_sum   = r_sum - r_rdata;
            n_count = r_count - 1'b1;
            if (r_cmd == CMD_POP_FRONT) begin
                n_front = slot_add(r_front, CNT_W'(1));
            end
        end else if (i_ctl.load) begin
            n_status = ST_OK;
        end
    end

    // Element store with one write port and a registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Queue control registers and scan sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_status   <= ST_OK;
            r_scan_idx <= '0;
            r_rd_pend  <= 1'b0;
            r_first    <= 1'b1;
        end else begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_status <= n_status;
            if (i_ctl.load) begin
                r_scan_idx <= '0;
                r_rd_pend  <= 1'b0;
                r_first    <= 1'b1;
            end else if (i_ctl.scan) begin
                r_rd_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (r_rd_pend) begin
                    r_first <= 1'b0;
                end
            end
        end
    end

    // Capture command payload and track the running maximum
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (i_ctl.scan && r_rd_pend) begin
            if (r_first || ($signed(r_rdata) > $signed(r_best))) begin
                r_best <= r_rdata;
            end
        end
    end

    // Result register; empty queue reads all ones
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_status <= r_status;
            if (is_empty) begin
                r_out_count <= '1;
                r_out_sum   <= '1;
                r_out_max   <= '1;
            end else begin
                r_out_count <= ELEM_CNT_W'(r_count);
                r_out_sum   <= r_sum;
                r_out_max   <= r_best;
            end
        end
    end

    assign o_status        = r_out_status;
    assign o_element_count = r_out_count;
    assign o_element_sum   = r_out_sum;
    assign o_largest_value = r_out_max;

endmodule

[design/bounded_deque_with_stats_unit.sv]
// A command passes through execute, a pop fixup when a pop removes an entry, the maximum
// scan and the output load. The unit takes a new command only once the last result is
// loaded into the output register; the maximum scan reads
// one stored entry per cycle through the single memory read port.
// A waiting result sits in the output register while the next command is taken.
// Reset (synchronous, active low) empties the queue; the element store is not cleared.
// ----------------------------------------------------------------------------
// bounded_deque_with_stats_unit
// Bounded double-ended queue reporting status, count, sum and maximum per command.
// ----------------------------------------------------------------------------
module bounded_deque_with_stats_unit
    import bdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_cmd_if.sink   i_cmd,
    bdq_res_if.source o_res
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    // Sequencer
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Storage and statistics
    bdq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_command       (i_cmd.command),
        .i_value         (i_cmd.value),
        .o_status        (o_res.status),
        .o_element_count (o_res.element_count),
        .o_element_sum   (o_res.element_sum),
        .o_largest_value (o_res.largest_value)
    );

endmodule

[design/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker
    import bdq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [STATUS_W-1:0]   i_status,
    input logic [ELEM_CNT_W-1:0] i_element_count,
    input logic [DATA_W-1:0]     i_element_sum,
    input logic [DATA_W-1:0]     i_largest_value
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // One command in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while busy");

    // A pop on empty leaves the queue empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY) |-> (i_element_count == '1))
        else $error("empty status with nonempty count");

    // A refused push means the queue is full
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_element_count == ELEM_CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    // Empty queue reports all statistics as all ones
    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_element_count == '1)
        |-> (i_element_sum == '1) && (i_largest_value == '1))
        else $error("empty queue with stale statistics");

endmodule

bind bounded_deque_with_stats_unit bdq_checker u_bdq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cmd.valid),
    .i_in_ready      (i_cmd.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_element_count (o_res.element_count),
    .i_element_sum   (o_res.element_sum),
    .i_largest_value (o_res.largest_value)
);

[bench/bdq_result_check.sv]
// ----------------------------------------------------------------------------
// bdq_result_check
// Watches the command and result channels of the bounded deque unit, keeps
// its own copy of the queue contents and compares every result transfer,
// field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module bdq_result_check
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bdq_cmd_if   i_cmd,
    bdq_res_if   i_res,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status               status;
        logic [ELEM_CNT_W-1:0] count;
        logic [DATA_W-1:0]     sum;
        logic [DATA_W-1:0]     largest;
    } t_deque_result;

    // Shadow copy of the circular store and its bookkeeping
    logic [DATA_W-1:0] shadow_store [DEPTH];
    int                head_slot;
    int                held;
    logic [DATA_W-1:0] held_sum;

    t_deque_result     awaited_results [$];
    int                mismatches;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        mismatches    = 0;
        head_slot     = 0;
        held          = 0;
        held_sum      = '0;
    end

    // Apply one command to the shadow queue and return the report it causes
    function automatic t_deque_result run_command(logic [CMD_W-1:0] code,
                                                  logic [DATA_W-1:0] val);
        t_deque_result            r;
        logic signed [DATA_W-1:0] best;
        int                       tail_slot;
        r.status = ST_OK;
        case (code)
            CMD_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    shadow_store[head_slot] = val;
                    held++;
                    held_sum += val;
                end
            end
            CMD_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_store[(head_slot + held) % DEPTH] = val;
                    held++;
                    held_sum += val;
                end
            end
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    held_sum -= shadow_store[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    tail_slot = (head_slot + held - 1) % DEPTH;
                    held_sum -= shadow_store[tail_slot];
                    held--;
                end
            end
            CMD_CLEAR: begin
                head_slot = 0;
                held      = 0;
                held_sum  = '0;
            end
            // query and the spare codes leave the queue alone
            default: ;
        endcase

        // Report all-ones statistics on an empty queue
        if (held == 0) begin
            r.count   = '1;
            r.sum     = '1;
            r.largest = '1;
        end else begin
            best = shadow_store[head_slot];
            for (int k = 1; k < held; k++) begin
                if ($signed(shadow_store[(head_slot + k) % DEPTH]) > best) begin
                    best = shadow_store[(head_slot + k) % DEPTH];
                end
            end
            r.count   = ELEM_CNT_W'(held);
            r.sum     = held_sum;
            r.largest = best;
        end
        return r;
    endfunction

    // Compare result transfers, then queue predictions for command transfers
    always @(posedge i_clk) begin : watch
        t_deque_result want;
        if (!i_rst_n) begin
            head_slot = 0;
            held      = 0;
            held_sum  = '0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no command outstanding: status %0d",
                           i_res.status);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        mismatches++;
                    end
                    if (i_res.element_count !== want.count) begin
                        $error("element_count: expected %0d, got %0d",
                               $signed(want.count), i_res.element_count);
                        mismatches++;
                    end
                    if (i_res.element_sum !== want.sum) begin
                        $error("element_sum: expected %0d, got %0d",
                               $signed(want.sum), i_res.element_sum);
                        mismatches++;
                    end
                    if (i_res.largest_value !== want.largest) begin
                        $error("largest_value: expected %0d, got %0d",
                               $signed(want.largest), i_res.largest_value);
                        mismatches++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                awaited_results.push_back(run_command(i_cmd.command, i_cmd.value));
            end
        end
        o_outstanding <= awaited_results.size();
        o_mismatches  <= mismatches;
    end

endmodule

[bench/bounded_deque_with_stats_unit_test.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_stats_unit_test
// Drives directed and random deque commands into the unit with random gaps
// and result back-pressure; the result check module predicts and compares.
// ----------------------------------------------------------------------------
module bounded_deque_with_stats_unit_test;
    import bdq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASE_LEN    = 60;
    localparam int CYCLE_LIMIT  = 400000;

    // Command codes the unit treats as query
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_NEG = 32'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    bit   hurry = 1'b0;

    bdq_cmd_if cmd_ch ();
    bdq_res_if res_ch ();

    bounded_deque_with_stats_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    bdq_result_check result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one command after a random gap and hold it until the transfer
    task automatic send_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] val);
        int gap;
        gap = hurry ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= code;
        cmd_ch.value   <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // Hold off until every predicted result has arrived
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(int bias);
        int roll;
        int push_share;
        roll = $urandom_range(0, 99);
        push_share = (bias == 0) ? 70 : (bias == 1) ? 28 : 48;
        if (roll < 2) return CMD_CLEAR;
        if (roll < 5) return CMD_QUERY;
        if (roll == 5) return CMD_SPARE_LO;
        if (roll == 6) return CMD_SPARE_HI;
        if (roll < 7 + push_share) begin
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return VAL_MAX;
        if (roll < 6) return VAL_MIN;
        if (roll < 8) return VAL_NEG;
        if (roll < 10) return '0;
        if (roll < 40) return DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
        return $urandom;
    endfunction

    // Accept results with a random stall before each one
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = hurry ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // Reset, directed commands, random phases, verdict
    initial begin
        int bias;
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_QUERY;
        cmd_ch.value   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pops and queries on an empty queue, spare codes included
        send_command(CMD_POP_FRONT, VAL_MAX);
        send_command(CMD_POP_BACK, VAL_MIN);
        send_command(CMD_QUERY, VAL_NEG);
        send_command(CMD_SPARE_LO, VAL_MAX);
        send_command(CMD_SPARE_HI, VAL_MIN);

        // Fill to the brim from both ends with extreme values
        send_command(CMD_PUSH_BACK, VAL_MAX);
        send_command(CMD_PUSH_FRONT, VAL_MIN);
        send_command(CMD_PUSH_BACK, VAL_NEG);
        send_command(CMD_PUSH_FRONT, '0);
        send_command(CMD_PUSH_BACK, VAL_MAX);
        for (int k = 5; k < DEPTH; k++) begin
            send_command(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
        end

        // Refuse pushes when full, then empty on a clear
        send_command(CMD_PUSH_FRONT, VAL_NEG);
        send_command(CMD_PUSH_BACK, VAL_MIN);
        send_command(CMD_CLEAR, VAL_MAX);
        wait_drained();

        // Random phases that lean toward filling, draining or neither
        bias = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                bias  = $urandom_range(0, 2);
                hurry = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            send_command(pick_command(bias), pick_value());
        end

        // Drain, allow stray results to show, then report
        wait_drained();
        repeat (DEPTH + 12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
